// File: design/sorted_key_table_unit_assert.svh
// Assertion macros for the sorted key table unit
`ifndef SORTED_KEY_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_TABLE_UNIT_ASSERT_SVH
// implication checked at each clock edge outside reset
`define SKT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define SKT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table unit.
// ----------------------------------------------------------------------------
package skt_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = 6;
    localparam int CntW = 7;
    localparam int AddrW = 48;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [AddrW-1:0] key;
        logic [AddrW-1:0] addr;
        logic [23:0]      len;
        logic [23:0]      ord;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
    } stat_t;
endpackage

// File: design/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Sorted key/value table with lookup, insert-or-replace and delete.
// ----------------------------------------------------------------------------
// channel | ports            | dir
// request | s_valid/s_ready  | in
// result  | m_valid/m_ready  | out
// A transaction is captured, then passes one compare-and-shift step.
// A new request is accepted only when idle or as the result is taken, so the
// compare/shift step takes one request at a time; result is held until taken.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [47:0] s_key,
    input  logic [47:0] s_entry_address,
    input  logic [23:0] s_entry_length,
    input  logic [23:0] s_entry_ordinal,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [47:0] m_hit_address,
    output logic [23:0] m_hit_length,
    output logic [23:0] m_hit_ordinal,
    output logic [6:0]  m_count_now
);
    skt_pkg::cmd_t cmd;

    skt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd)
    );

    skt_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .req_type(s_req_type),
        .key(s_key), .entry_address(s_entry_address),
        .entry_length(s_entry_length), .entry_ordinal(s_entry_ordinal),
        .status(m_status), .found(m_found), .hit_address(m_hit_address),
        .hit_length(m_hit_length), .hit_ordinal(m_hit_ordinal),
        .count_now(m_count_now)
    );
endmodule

// File: design/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Request sequencer: capture, compare and update, result hold.
// ----------------------------------------------------------------------------
module skt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output skt_pkg::cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT: begin
                if (m_ready) state_next = s_valid ? S_EXEC : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = (state_reg == S_OUT);
    assign s_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && m_ready);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.update = (state_reg == S_EXEC);
endmodule

// File: design/skt_datapath.sv
// ----------------------------------------------------------------------------
// skt_datapath
// Shift-register table with broadcast compare, insert and delete shifting.
// ----------------------------------------------------------------------------
module skt_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  skt_pkg::cmd_t               cmd,
    input  logic [1:0]                  req_type,
    input  logic [skt_pkg::AddrW-1:0]   key,
    input  logic [skt_pkg::AddrW-1:0]   entry_address,
    input  logic [23:0]                 entry_length,
    input  logic [23:0]                 entry_ordinal,
    output logic [1:0]                  status,
    output logic                        found,
    output logic [skt_pkg::AddrW-1:0]   hit_address,
    output logic [23:0]                 hit_length,
    output logic [23:0]                 hit_ordinal,
    output logic [skt_pkg::CntW-1:0]    count_now
);
    localparam int D = skt_pkg::TableDepth;

    skt_pkg::entry_t tab_reg [D];
    skt_pkg::entry_t req_reg;
    logic [1:0] op_reg;
    logic [skt_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic [1:0] status_reg;
    logic found_reg;
    logic [skt_pkg::AddrW-1:0] ha_reg;
    logic [23:0] hl_reg, ho_reg;

    logic [D-1:0] live, lt, eq;
    logic hit;
    skt_pkg::entry_t hit_e;
    logic full;
    skt_pkg::stat_t st;

    always_comb begin
        hit_e = '0;
        for (int i = 0; i < D; i++) begin
            live[i] = (i < int'(cnt_reg));
            lt[i] = live[i] && (tab_reg[i].key < req_reg.key);
            eq[i] = live[i] && (tab_reg[i].key == req_reg.key);
            if (eq[i]) hit_e = hit_e | tab_reg[i];
        end
        hit = |eq;
        full = (cnt_reg == skt_pkg::CntW'(D));
        st.hit = hit;
        st.full = full;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (op_reg == skt_pkg::REQ_INSERT && !st.hit && !st.full) cnt_next = cnt_reg + 1'b1;
        if (op_reg == skt_pkg::REQ_DELETE && st.hit) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.update) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= '{key, entry_address, entry_length, entry_ordinal};
            op_reg <= req_type;
        end
        if (cmd.update) begin
            found_reg <= st.hit;
            ha_reg <= st.hit ? hit_e.addr : '0;
            hl_reg <= st.hit ? hit_e.len : '0;
            ho_reg <= st.hit ? hit_e.ord : '0;
            if (op_reg == skt_pkg::REQ_INSERT) begin
                status_reg <= (!st.hit && st.full) ? skt_pkg::ST_FULL : skt_pkg::ST_DONE;
            end else begin
                status_reg <= st.hit ? skt_pkg::ST_DONE : skt_pkg::ST_ABSENT;
            end
            if (op_reg == skt_pkg::REQ_INSERT) begin
                if (st.hit) begin
                    for (int i = 0; i < D; i++) begin
                        if (eq[i]) tab_reg[i] <= req_reg;
                    end
                end else if (!st.full) begin
                    if (!lt[0]) tab_reg[0] <= req_reg;
                    for (int i = 1; i < D; i++) begin
                        if (!lt[i] && (i <= int'(cnt_reg))) begin
                            tab_reg[i] <= lt[i-1] ? req_reg : tab_reg[i-1];
                        end
                    end
                end
            end else if (op_reg == skt_pkg::REQ_DELETE && st.hit) begin
                for (int i = 0; i < D-1; i++) begin
                    if (!lt[i] && live[i]) tab_reg[i] <= tab_reg[i+1];
                end
            end
        end
    end

    assign status = status_reg;
    assign found = found_reg;
    assign hit_address = ha_reg;
    assign hit_length = hl_reg;
    assign hit_ordinal = ho_reg;
    assign count_now = cnt_reg;
endmodule

// File: design/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks of the sorted key table unit.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_assert.svh"
module skt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic       m_found,
    input logic [6:0] m_count_now
);
    `SKT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))
    `SKT_ASSERT_IMP(a_cnt, aclk, aresetn, m_valid, m_count_now <= 7'd64)
    `SKT_ASSERT_IMP(a_full, aclk, aresetn, m_valid && (m_status == skt_pkg::ST_FULL), !m_found)
    `SKT_ASSERT_NEXT(a_lat, aclk, aresetn, s_valid && s_ready, !m_valid)
endmodule

bind sorted_key_table_unit skt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_found(m_found), .m_count_now(m_count_now)
);

// File: tb/sorted_key_table_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb
// Self-checking bench: lookup, insert-or-replace and delete requests with
// random idle gaps on both channels, checked against a behavioral sorted table.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_tb;
    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] key;
        logic [47:0] addr;
        logic [23:0] len;
        logic [23:0] ord;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [47:0] addr;
        logic [23:0] len;
        logic [23:0] ord;
        logic [6:0]  count;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [47:0] s_key = '0;
    logic [47:0] s_entry_address = '0;
    logic [23:0] s_entry_length = '0;
    logic [23:0] s_entry_ordinal = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [47:0] m_hit_address;
    logic [23:0] m_hit_length;
    logic [23:0] m_hit_ordinal;
    logic [6:0]  m_count_now;

    sorted_key_table_unit DUT (.*);

    request_t  pending_reqs[$];
    response_t expected_resps[$];
    skt_pkg::entry_t table_model[skt_pkg::TableDepth];
    int        table_count = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    bit        stim_done = 1'b0;
    bit        tail_mode = 1'b0;
    logic [47:0] key_pool[8];

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic response_t predict_table(request_t r);
        response_t res;
        int pos;
        bit hit;
        res = '0;
        pos = 0;
        while (pos < table_count && table_model[pos].key < r.key) pos++;
        hit = (pos < table_count) && (table_model[pos].key == r.key);
        res.found = hit;
        if (hit) begin
            res.addr = table_model[pos].addr;
            res.len = table_model[pos].len;
            res.ord = table_model[pos].ord;
        end
        if (r.req_type == skt_pkg::REQ_INSERT) begin
            if (hit) begin
                table_model[pos] = '{r.key, r.addr, r.len, r.ord};
            end else if (table_count >= skt_pkg::TableDepth) begin
                res.status = skt_pkg::ST_FULL;
            end else begin
                for (int i = table_count; i > pos; i--) table_model[i] = table_model[i-1];
                table_model[pos] = '{r.key, r.addr, r.len, r.ord};
                table_count++;
            end
        end else if (r.req_type == skt_pkg::REQ_DELETE) begin
            if (hit) begin
                for (int i = pos; i < table_count - 1; i++) table_model[i] = table_model[i+1];
                table_count--;
            end else begin
                res.status = skt_pkg::ST_ABSENT;
            end
        end else if (!hit) begin
            res.status = skt_pkg::ST_ABSENT;
        end
        res.count = table_count[6:0];
        return res;
    endfunction

    function automatic request_t make_req(logic [1:0] t, logic [47:0] k);
        request_t r;
        r.req_type = t;
        r.key = k;
        r.addr = 48'({$urandom, $urandom});
        r.len = 24'($urandom);
        r.ord = 24'($urandom);
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(predict_table('{s_req_type, s_key,
                    s_entry_address, s_entry_length, s_entry_ordinal}));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= r.req_type;
                    s_key <= r.key;
                    s_entry_address <= r.addr;
                    s_entry_length <= r.len;
                    s_entry_ordinal <= r.ord;
                    send_gap <= tail_mode ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                response_t got, want;
                got = '{m_status, m_found, m_hit_address, m_hit_length,
                        m_hit_ordinal, m_count_now};
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %p", got);
                end else begin
                    want = expected_resps.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
                recv_gap = tail_mode ? 0 : $urandom_range(0, 7);
            end
            if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL sorted_key_table_unit");
            $finish;
        end
    end

    initial begin
        logic [47:0] k;
        // directed: extremes, every op, replace, delete hit/miss, unused type
        pending_reqs.push_back(make_req(skt_pkg::REQ_LOOKUP, 48'h0));
        pending_reqs.push_back(make_req(skt_pkg::REQ_DELETE, 48'hFFFF_FFFF_FFFF));
        pending_reqs.push_back('{skt_pkg::REQ_INSERT, 48'hFFFF_FFFF_FFFF,
                                 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF});
        pending_reqs.push_back('{skt_pkg::REQ_INSERT, 48'h0, 48'h0, 24'h0, 24'h0});
        pending_reqs.push_back(make_req(skt_pkg::REQ_INSERT, 48'h8000_0000_0000));
        pending_reqs.push_back(make_req(skt_pkg::REQ_LOOKUP, 48'hFFFF_FFFF_FFFF));
        pending_reqs.push_back(make_req(skt_pkg::REQ_INSERT, 48'h0));
        pending_reqs.push_back(make_req(skt_pkg::REQ_RSVD, 48'h0));
        pending_reqs.push_back(make_req(skt_pkg::REQ_RSVD, 48'h1234));
        pending_reqs.push_back(make_req(skt_pkg::REQ_DELETE, 48'h8000_0000_0000));
        pending_reqs.push_back(make_req(skt_pkg::REQ_DELETE, 48'h8000_0000_0000));
        pending_reqs.push_back(make_req(skt_pkg::REQ_LOOKUP, 48'h0));
        pending_reqs.push_back(make_req(skt_pkg::REQ_DELETE, 48'h0));
        pending_reqs.push_back(make_req(skt_pkg::REQ_DELETE, 48'hFFFF_FFFF_FFFF));
        // random: fill to full with a small key space, then churn
        for (int i = 0; i < 8; i++) key_pool[i] = 48'({$urandom, $urandom});
        for (int i = 0; i < 1800; i++) begin
            int sel;
            logic [1:0] t;
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0: k = 48'({$urandom, $urandom});
                1: k = key_pool[$urandom_range(0, 7)] + 48'($urandom_range(0, 15));
                default: k = 48'($urandom_range(0, 95));
            endcase
            if ((i / 300) % 2 == 0) begin
                t = (sel < 70) ? skt_pkg::REQ_INSERT : (sel < 85) ? skt_pkg::REQ_LOOKUP
                    : (sel < 97) ? skt_pkg::REQ_DELETE : skt_pkg::REQ_RSVD;
            end else begin
                t = (sel < 30) ? skt_pkg::REQ_INSERT : (sel < 55) ? skt_pkg::REQ_LOOKUP
                    : (sel < 97) ? skt_pkg::REQ_DELETE : skt_pkg::REQ_RSVD;
            end
            pending_reqs.push_back(make_req(t, k));
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid);
        tail_mode = 1'b1;
        wait (expected_resps.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("PASS sorted_key_table_unit");
        end else begin
            $display("FAIL sorted_key_table_unit");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/skt_pkg.sv
design/skt_ctrl.sv
design/skt_datapath.sv
design/sorted_key_table_unit.sv
design/skt_checker.sv
tb/sorted_key_table_unit_tb.sv
